/* rtl/mmc_pkg.sv */
// shared types, register indexes and reset values for the motion mood classifier
package mmc_pkg;

    localparam int unsigned CfgWidth   = 16;
    localparam int unsigned CfgIdxBits = 3;
    localparam int unsigned AccelWidth = 16;
    localparam int unsigned TimeWidth  = 32;
    localparam int unsigned MoodWidth  = 3;

    // magnitude of a 16-bit signed value, kept one bit wider than the sample
    localparam int unsigned MagWidth = AccelWidth + 1;

    typedef enum logic [CfgIdxBits-1:0] {
        REG_SHAKE_THRESHOLD    = 3'd0,
        REG_TILT_THRESHOLD     = 3'd1,
        REG_MOVE_THRESHOLD     = 3'd2,
        REG_FACE_DOWN_Z_LIMIT  = 3'd3,
        REG_FACE_FLAT_XY_LIMIT = 3'd4,
        REG_HOLD_MS            = 3'd5
    } cfg_index_t;

    typedef enum logic [MoodWidth-1:0] {
        MOOD_IDLE     = 3'd0,
        MOOD_DIZZY    = 3'd1,
        MOOD_TOUCHED  = 3'd2,
        MOOD_TILTED   = 3'd3,
        MOOD_MOVING   = 3'd4,
        MOOD_SLEEPING = 3'd5
    } mood_t;

    localparam logic [CfgWidth-1:0]        ShakeThresholdReset  = 16'd3840;
    localparam logic [CfgWidth-1:0]        TiltThresholdReset   = 16'd1024;
    localparam logic [CfgWidth-1:0]        MoveThresholdReset   = 16'd384;
    localparam logic signed [CfgWidth-1:0] FaceDownZLimitReset  = -16'sd1536;
    localparam logic [CfgWidth-1:0]        FaceFlatXyLimitReset = 16'd1280;
    localparam logic [CfgWidth-1:0]        HoldMsReset          = 16'd2000;

    typedef struct packed {
        logic [CfgWidth-1:0]        shake_threshold;
        logic [CfgWidth-1:0]        tilt_threshold;
        logic [CfgWidth-1:0]        move_threshold;
        logic signed [CfgWidth-1:0] face_down_z_limit;
        logic [CfgWidth-1:0]        face_flat_xy_limit;
        logic [CfgWidth-1:0]        hold_ms;
    } cfg_t;

    typedef struct packed {
        logic signed [AccelWidth-1:0] accel_x;
        logic signed [AccelWidth-1:0] accel_y;
        logic signed [AccelWidth-1:0] accel_z;
        logic                         touched;
        logic [TimeWidth-1:0]         now_ms;
    } sample_t;

    // exact magnitude of a signed sample, no wrap at the most negative value
    function automatic logic [MagWidth-1:0] mag(input logic signed [AccelWidth-1:0] v);
        logic [MagWidth-1:0] ext;
        ext = {v[AccelWidth-1], v};
        return v[AccelWidth-1] ? (MagWidth'(0) - ext) : ext;
    endfunction

endpackage

/* rtl/mmc_cfg_regs.sv */
// configuration register bank for the motion mood classifier
module mmc_cfg_regs
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [mmc_pkg::CfgIdxBits-1:0]  cfg_index,
    input  logic [mmc_pkg::CfgWidth-1:0]    cfg_wdata,
    output mmc_pkg::cfg_t                   cfg
);

    mmc_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.shake_threshold    <= mmc_pkg::ShakeThresholdReset;
            cfg_reg.tilt_threshold     <= mmc_pkg::TiltThresholdReset;
            cfg_reg.move_threshold     <= mmc_pkg::MoveThresholdReset;
            cfg_reg.face_down_z_limit  <= mmc_pkg::FaceDownZLimitReset;
            cfg_reg.face_flat_xy_limit <= mmc_pkg::FaceFlatXyLimitReset;
            cfg_reg.hold_ms            <= mmc_pkg::HoldMsReset;
        end
        else if (cfg_we)
        begin
            // unknown indexes are dropped
            unique case (mmc_pkg::cfg_index_t'(cfg_index))
                mmc_pkg::REG_SHAKE_THRESHOLD:    cfg_reg.shake_threshold    <= cfg_wdata;
                mmc_pkg::REG_TILT_THRESHOLD:     cfg_reg.tilt_threshold     <= cfg_wdata;
                mmc_pkg::REG_MOVE_THRESHOLD:     cfg_reg.move_threshold     <= cfg_wdata;
                mmc_pkg::REG_FACE_DOWN_Z_LIMIT:  cfg_reg.face_down_z_limit  <= $signed(cfg_wdata);
                mmc_pkg::REG_FACE_FLAT_XY_LIMIT: cfg_reg.face_flat_xy_limit <= cfg_wdata;
                mmc_pkg::REG_HOLD_MS:            cfg_reg.hold_ms            <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/mmc_core.sv */
// mood priority chain with the mood and timestamp state
module mmc_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  mmc_pkg::sample_t  sample,
    input  mmc_pkg::cfg_t     cfg,
    output mmc_pkg::mood_t    mood_next
);

    mmc_pkg::mood_t                    mood_reg;
    logic [mmc_pkg::TimeWidth-1:0]     last_change_reg;
    logic [mmc_pkg::TimeWidth-1:0]     last_change_next;

    logic [mmc_pkg::MagWidth-1:0]      ax;
    logic [mmc_pkg::MagWidth-1:0]      ay;
    logic [mmc_pkg::MagWidth-1:0]      force_mag;
    logic [mmc_pkg::TimeWidth-1:0]     elapsed;
    logic [mmc_pkg::TimeWidth-1:0]     hold_ext;
    logic                              over_shake;
    logic                              over_tilt;
    logic                              over_move;
    logic                              face_down;

    assign ax        = mmc_pkg::mag(sample.accel_x);
    assign ay        = mmc_pkg::mag(sample.accel_y);
    assign force_mag = (ax > ay) ? ax : ay;
    assign elapsed   = sample.now_ms - last_change_reg;
    assign hold_ext  = {{(mmc_pkg::TimeWidth - mmc_pkg::CfgWidth){1'b0}}, cfg.hold_ms};

    assign over_shake = force_mag > {1'b0, cfg.shake_threshold};
    assign over_tilt  = force_mag > {1'b0, cfg.tilt_threshold};
    assign over_move  = force_mag > {1'b0, cfg.move_threshold};
    assign face_down  = (sample.accel_z < cfg.face_down_z_limit) &&
                        (ax < {1'b0, cfg.face_flat_xy_limit}) &&
                        (ay < {1'b0, cfg.face_flat_xy_limit}) &&
                        (force_mag < {1'b0, cfg.move_threshold});

    always_comb
    begin
        mood_next        = mood_reg;
        last_change_next = last_change_reg;
        priority if (over_shake)
        begin
            mood_next        = mmc_pkg::MOOD_DIZZY;
            last_change_next = sample.now_ms;
        end
        else if (mood_reg == mmc_pkg::MOOD_DIZZY && elapsed < hold_ext)
        begin
            // dizzy hold, nothing moves
        end
        else if (sample.touched && mood_reg != mmc_pkg::MOOD_TILTED)
        begin
            mood_next        = mmc_pkg::MOOD_TOUCHED;
            last_change_next = sample.now_ms;
        end
        else if (over_tilt)
        begin
            mood_next = mmc_pkg::MOOD_TILTED;
        end
        else if (over_move)
        begin
            mood_next        = mmc_pkg::MOOD_MOVING;
            last_change_next = sample.now_ms;
        end
        else if (face_down)
        begin
            // face down keeps the mood until the hold time has gone by
            if (elapsed > hold_ext)
            begin
                mood_next = mmc_pkg::MOOD_SLEEPING;
            end
        end
        else
        begin
            mood_next = mmc_pkg::MOOD_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mood_reg        <= mmc_pkg::MOOD_IDLE;
            last_change_reg <= '0;
        end
        else if (fire)
        begin
            mood_reg        <= mood_next;
            last_change_reg <= last_change_next;
        end
    end

    a_state_holds_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(mood_reg) && $stable(last_change_reg))
        else $error("mood state changed without a sample");

    a_shake_sets_dizzy: assert property (@(posedge clk) disable iff (!rst_n)
        fire && over_shake |=> mood_reg == mmc_pkg::MOOD_DIZZY &&
            last_change_reg == $past(sample.now_ms))
        else $error("shake did not give dizzy with a new timestamp");

    a_tilt_keeps_time: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !over_shake && mood_next == mmc_pkg::MOOD_TILTED |=> $stable(last_change_reg))
        else $error("tilt changed the timestamp");

endmodule

/* rtl/motion_mood_classifier_top.sv */
// top level: input register, mood classifier, result register
// a sample passes the input register, then the result register, before its result is valid
// throughput: one sample per cycle while the output side takes results; the mood state feeds back combinationally
// both registers keep moving while the output side takes results; stall backs up per stage
// reset (async, active low) clears valid flags, mood to idle, timestamp to zero
// and loads the default thresholds and hold time
module motion_mood_classifier_top
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [mmc_pkg::CfgIdxBits-1:0]         cfg_index,
    input  logic [mmc_pkg::CfgWidth-1:0]           cfg_wdata,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [mmc_pkg::AccelWidth-1:0]  accel_x,
    input  logic signed [mmc_pkg::AccelWidth-1:0]  accel_y,
    input  logic signed [mmc_pkg::AccelWidth-1:0]  accel_z,
    input  logic                                   touched,
    input  logic [mmc_pkg::TimeWidth-1:0]          now_ms,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [mmc_pkg::MoodWidth-1:0]          mood
);

    mmc_pkg::cfg_t     cfg;
    mmc_pkg::sample_t  sample_reg;
    logic              sample_valid_reg;
    logic              out_valid_reg;
    mmc_pkg::mood_t    out_mood_reg;
    mmc_pkg::mood_t    mood_next;
    logic              out_free;
    logic              core_fire;
    logic              in_take;

    assign out_free  = !out_valid_reg || !out_stall;
    assign core_fire = sample_valid_reg && out_free;
    assign in_stall  = sample_valid_reg && !out_free;
    assign in_take   = in_valid && !in_stall;

    mmc_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mmc_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (core_fire),
        .sample    (sample_reg),
        .cfg       (cfg),
        .mood_next (mood_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (in_take || core_fire)
            begin
                sample_valid_reg <= in_take;
            end
            if (out_free)
            begin
                out_valid_reg <= sample_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            sample_reg.accel_x <= accel_x;
            sample_reg.accel_y <= accel_y;
            sample_reg.accel_z <= accel_z;
            sample_reg.touched <= touched;
            sample_reg.now_ms  <= now_ms;
        end
        if (core_fire)
        begin
            out_mood_reg <= mood_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign mood      = out_mood_reg;

endmodule
